FILE: rtl/sonf_pkg.sv
// Shared constants and register indexes for the second-order notch filter.
package sonf_pkg;

    // Sample and configuration widths
    localparam int SAMPLE_W  = 32;
    localparam int PRS_W     = 31;
    localparam int COS_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Fraction bits of the configuration registers and default coefficient precision
    localparam int REG_FRAC_BITS           = 30;
    localparam int DEFAULT_COEF_FRAC_BITS  = 30;

    // Operand width of the shared signed multiplier
    localparam int MUL_W = 34;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_POLE_RADIUS_SQUARED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTCH_COSINE        = 2'd1;

    // Coefficient bounds (1.0 in Q2.30)
    localparam logic [PRS_W-1:0]        PRS_MAX = 31'd1073741824;
    localparam logic signed [COS_W-1:0] COS_MAX = 32'sd1073741824;
    localparam logic signed [COS_W-1:0] COS_MIN = -32'sd1073741824;

    // Output sample range
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fff_ffff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

endpackage

FILE: rtl/second_order_notch_filter_core.sv
// Second-order IIR notch filter core with one shared multiplier under a sequencer.
//
// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_ready   sample_in
// result    out        result_valid / result_ready   sample_out, clipped
// cfg       in         cfg_we (no wait)              cfg_index, cfg_data
//
// After the accepting idle cycle the single 34x34 signed multiplier is used five times in
// turn, followed by one accumulate step, one round step and one output step, after which
// the core is ready again. The result appears in the cycle after the output step.
// rst_n clears the coefficients and the filter history to zero.
// A result waiting on result_ready holds the core in its output step; the next sample
// may be accepted while the last result is still waiting.
module second_order_notch_filter_core
    import sonf_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEFAULT_COEF_FRAC_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        sample_valid,
    output logic                        sample_ready,
    input  logic signed [SAMPLE_W-1:0]  sample_in,

    output logic                        result_valid,
    input  logic                        result_ready,
    output logic signed [SAMPLE_W-1:0]  sample_out,
    output logic                        clipped,

    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data
);

    // Derived widths and shifts
    localparam int DROP   = REG_FRAC_BITS - COEF_FRAC_BITS;
    localparam int DQ_W   = COEF_FRAC_BITS + 1;
    localparam int CQ_W   = COEF_FRAC_BITS + 2;
    localparam int SUM_W  = COEF_FRAC_BITS + 2;
    localparam int PROD_W = 2 * MUL_W;
    localparam int K      = 2 * COEF_FRAC_BITS + 1;
    localparam int ACC_W  = 2 * COEF_FRAC_BITS + 37;
    localparam int Q_W    = ACC_W - K;
    localparam int HALF_W = SAMPLE_W;
    localparam int DIFF_W = SAMPLE_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_D,
        S_MUL_C,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_RND,
        S_OUT
    } state_t;

    state_t                      state_reg, state_next;

    // Configuration registers
    logic [PRS_W-1:0]            prs_reg;
    logic signed [COS_W-1:0]     cos_reg;

    // Filter history
    logic signed [SAMPLE_W-1:0]  x1_reg, x1_next;
    logic signed [SAMPLE_W-1:0]  x2_reg, x2_next;
    logic signed [SAMPLE_W-1:0]  y1_reg, y1_next;
    logic signed [SAMPLE_W-1:0]  y2_reg, y2_next;

    // Output register
    logic                        rv_reg, rv_next;
    logic signed [SAMPLE_W-1:0]  out_reg, out_next;
    logic                        clip_reg, clip_next;

    // Datapath registers
    logic signed [SAMPLE_W-1:0]  x_reg, x_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [DIFF_W-1:0]    rhi_reg, rhi_next;
    logic signed [Q_W-1:0]       q_reg, q_next;

    // Combinational helpers
    logic [PRS_W-1:0]            d_cl;
    logic signed [COS_W-1:0]     c_cl;
    logic [DQ_W-1:0]             dq;
    logic signed [CQ_W-1:0]      cq;
    logic [SUM_W-1:0]            coef_sum;
    logic signed [DIFF_W-1:0]    in_sum;
    logic signed [DIFF_W-1:0]    diff;
    logic signed [MUL_W-1:0]     mul_a, mul_b;
    logic signed [ACC_W-1:0]     prod_ext;
    logic signed [ACC_W-1:0]     addend;
    logic signed [Q_W-1:0]       q_trunc;
    logic                        rnd_up;
    logic                        out_free;
    logic                        sat_hi, sat_lo;

    // Clamp and reduce the coefficients
    always_comb
    begin
        d_cl = (prs_reg > PRS_MAX) ? PRS_MAX : prs_reg;
        if (cos_reg > COS_MAX)
        begin
            c_cl = COS_MAX;
        end
        else if (cos_reg < COS_MIN)
        begin
            c_cl = COS_MIN;
        end
        else
        begin
            c_cl = cos_reg;
        end
        dq       = d_cl[PRS_W-1:DROP];
        cq       = c_cl[COS_W-1:DROP];
        coef_sum = (SUM_W'(1) << COEF_FRAC_BITS) + SUM_W'(dq);
        in_sum   = DIFF_W'(x_reg) + DIFF_W'(x2_reg);
        diff     = DIFF_W'(y1_reg) - DIFF_W'(x1_reg);
    end

    // Select multiplier operands per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_A:
            begin
                mul_a = $signed({{(MUL_W-SUM_W){1'b0}}, coef_sum});
                mul_b = MUL_W'(in_sum);
            end
            S_MUL_D:
            begin
                mul_a = $signed({{(MUL_W-DQ_W){1'b0}}, dq});
                mul_b = MUL_W'(y2_reg);
            end
            S_MUL_C:
            begin
                mul_a = MUL_W'(cq);
                mul_b = MUL_W'(diff);
            end
            S_MUL_LO:
            begin
                mul_a = $signed({{(MUL_W-SUM_W){1'b0}}, coef_sum});
                mul_b = $signed({{(MUL_W-HALF_W){1'b0}}, prod_reg[HALF_W-1:0]});
            end
            S_MUL_HI:
            begin
                mul_a = $signed({{(MUL_W-SUM_W){1'b0}}, coef_sum});
                mul_b = MUL_W'(rhi_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Select the shifted product added to the accumulator
    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        case (state_reg)
            S_MUL_D:  addend = prod_ext <<< COEF_FRAC_BITS;
            S_MUL_C:  addend = -(prod_ext <<< (COEF_FRAC_BITS + 1));
            S_MUL_HI: addend = prod_ext <<< 1;
            S_ACC:    addend = prod_ext <<< HALF_W + 1;
            default:  addend = '0;
        endcase
    end

    // Truncate toward zero and saturate
    always_comb
    begin
        q_trunc = acc_reg[ACC_W-1:K];
        rnd_up  = acc_reg[ACC_W-1] & (|acc_reg[K-1:0]);
        sat_hi  = q_reg > Q_W'(SAMPLE_MAX);
        sat_lo  = q_reg < Q_W'(SAMPLE_MIN);
    end

    // Sequencer next state and datapath
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        y1_next    = y1_reg;
        y2_next    = y2_reg;
        rv_next    = rv_reg;
        out_next   = out_reg;
        clip_next  = clip_reg;
        rhi_next   = rhi_reg;
        q_next     = q_reg;
        prod_next  = PROD_W'(mul_a * mul_b);
        acc_next   = acc_reg + addend;
        out_free   = !rv_reg || result_ready;

        // Drop the result once taken
        if (rv_reg && result_ready)
        begin
            rv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    x_next     = sample_in;
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                acc_next   = '0;
                state_next = S_MUL_D;
            end
            S_MUL_D:
            begin
                state_next = S_MUL_C;
            end
            S_MUL_C:
            begin
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                rhi_next   = prod_reg[HALF_W+DIFF_W-1:HALF_W];
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = S_RND;
            end
            S_RND:
            begin
                q_next     = q_trunc + $signed({{(Q_W-1){1'b0}}, rnd_up});
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    if (sat_hi)
                    begin
                        out_next = SAMPLE_MAX;
                    end
                    else if (sat_lo)
                    begin
                        out_next = SAMPLE_MIN;
                    end
                    else
                    begin
                        out_next = q_reg[SAMPLE_W-1:0];
                    end
                    clip_next  = sat_hi || sat_lo;
                    rv_next    = 1'b1;
                    x2_next    = x1_reg;
                    x1_next    = x_reg;
                    y2_next    = y1_reg;
                    y1_next    = out_next;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, history and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            x1_reg    <= '0;
            x2_reg    <= '0;
            y1_reg    <= '0;
            y2_reg    <= '0;
            rv_reg    <= 1'b0;
            out_reg   <= '0;
            clip_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            x1_reg    <= x1_next;
            x2_reg    <= x2_next;
            y1_reg    <= y1_next;
            y2_reg    <= y2_next;
            rv_reg    <= rv_next;
            out_reg   <= out_next;
            clip_reg  <= clip_next;
        end
    end

    // Advance datapath registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rhi_reg  <= rhi_next;
        q_reg    <= q_next;
    end

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prs_reg <= '0;
            cos_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POLE_RADIUS_SQUARED: prs_reg <= cfg_data[PRS_W-1:0];
                REG_NOTCH_COSINE:        cos_reg <= cfg_data[COS_W-1:0];
                default:                 ;
            endcase
        end
    end

    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = rv_reg;
    assign sample_out   = out_reg;
    assign clipped      = clip_reg;

    // A transaction on the input starts the sequence and blocks further input
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> (!sample_ready && state_reg == S_MUL_A))
        else $error("sample accepted but sequencer did not start");

    // A clipped result carries one of the range bounds
    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && clipped) |-> (sample_out == SAMPLE_MAX || sample_out == SAMPLE_MIN))
        else $error("clipped result is not a range bound");

    // A new result comes only from the output step and enters the history
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg == S_OUT) && y1_reg == sample_out))
        else $error("result not produced by output step or history mismatch");

    // The output step never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && result_valid && !result_ready) |=>
            (state_reg == S_OUT && $stable(sample_out)))
        else $error("waiting result overwritten");

endmodule
